// ----- hdl/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants for the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

	localparam int HANDLE_BITS  = 32;
	localparam int INDEX_BITS   = 24;
	localparam int GEN_BITS     = 8;
	localparam int KIND_BITS    = 2;
	localparam int PORT_PAYLOAD = 32;
	localparam int S_TDATA_BITS = 72;
	localparam int M_TDATA_BITS = 72;

	localparam logic [GEN_BITS-1:0] GEN_FIRST = 8'd1;
	localparam logic [GEN_BITS-1:0] GEN_LAST  = 8'd255;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_LOOKUP  = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_STALE   = 3'd2,
		ST_KIND    = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_EXEC = 1'b1
	} back_state_t;

	// classified request passed from front to back
	typedef struct packed {
		cmd_t                     cmd;
		logic [INDEX_BITS-1:0]    idx;
		logic [GEN_BITS-1:0]      gen;
		logic                     idx_bad;   // zero index, or at or beyond table size
		logic [KIND_BITS-1:0]     kind;
		logic                     check;
		logic [PORT_PAYLOAD-1:0]  payload;
	} req_t;

endpackage

// ----- hdl/ght_front.sv -----
// ----------------------------------------------------------------------------
// ght_front
// Accepts input words, splits the handle, flags bad indexes and holds the
// requests in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ght_front #(
	parameter int SLOTS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ght_pkg::S_TDATA_BITS-1:0] s_tdata,
	input  logic [1:0]                      s_tuser,
	output logic                            req_valid,
	output ght_pkg::req_t                   req,
	input  logic                            req_pop
);
	import ght_pkg::*;

	req_t        q_mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	req_t        cls;
	logic [INDEX_BITS-1:0] idx;

	assign idx = s_tdata[INDEX_BITS-1:0];

	always_comb begin
		cls.cmd     = cmd_t'(s_tuser);
		cls.idx     = idx;
		cls.gen     = s_tdata[HANDLE_BITS-1:INDEX_BITS];
		cls.idx_bad = (idx == '0) ||
			({1'b0, idx} >= (INDEX_BITS+1)'(SLOTS));
		cls.kind    = s_tdata[HANDLE_BITS+KIND_BITS-1:HANDLE_BITS];
		cls.check   = s_tdata[HANDLE_BITS+KIND_BITS];
		cls.payload = s_tdata[HANDLE_BITS+KIND_BITS+PORT_PAYLOAD:HANDLE_BITS+KIND_BITS+1];
	end

	assign s_tready  = (count_q != 2'd2);
	assign push      = s_tvalid && s_tready;
	assign req_valid = (count_q != 2'd0);
	assign req       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (req_pop && req_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(req_pop && req_valid);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ----- hdl/ght_back.sv -----
// ----------------------------------------------------------------------------
// ght_back
// Executes requests: reads the slot and free stack, then checks, updates
// and writes back, and places the result in the output register.
// ----------------------------------------------------------------------------
module ght_back #(
	parameter int SLOTS        = 256,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  ght_pkg::req_t                    req,
	output logic                             req_pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ght_pkg::M_TDATA_BITS-1:0] m_tdata
);
	import ght_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int PW = (PAYLOAD_BITS < PORT_PAYLOAD) ? PAYLOAD_BITS : PORT_PAYLOAD;
	localparam int EW = 1 + GEN_BITS + KIND_BITS + PW;
	localparam int FW = IW + GEN_BITS;

	// slot entry: {valid, generation, kind, payload}
	logic [EW-1:0] slot_mem [SLOTS];
	logic [FW-1:0] free_mem [SLOTS];

	back_state_t state_q, state_d;
	req_t        req_s1;
	logic [EW-1:0] slot_rd_s1;
	logic [FW-1:0] free_rd_s1;
	logic [CW-1:0] in_use_q;
	logic [CW-1:0] fcount_q;
	logic          out_valid_q;
	logic [M_TDATA_BITS-1:0] out_data_q;

	logic          done;
	logic          slot_we;
	logic [IW-1:0] slot_wa;
	logic [EW-1:0] slot_wd;
	logic          free_we;
	logic [FW-1:0] free_wd;
	logic          in_use_inc;
	logic          fcount_inc;
	logic          fcount_dec;
	status_t       status;
	logic [HANDLE_BITS-1:0]  handle_out;
	logic [PORT_PAYLOAD-1:0] payload_out;
	logic [KIND_BITS-1:0]    kind_out;

	logic [IW-1:0]        idx_l;
	logic                 rd_valid;
	logic [GEN_BITS-1:0]  rd_gen;
	logic [KIND_BITS-1:0] rd_kind;
	logic [PW-1:0]        rd_payload;
	logic                 range_bad;
	logic                 stale;
	logic [IW-1:0]        f_idx;
	logic [GEN_BITS-1:0]  f_gen;
	logic [GEN_BITS-1:0]  next_gen;

	assign idx_l      = req_s1.idx[IW-1:0];
	assign rd_valid   = slot_rd_s1[EW-1];
	assign rd_gen     = slot_rd_s1[EW-2:EW-1-GEN_BITS];
	assign rd_kind    = slot_rd_s1[PW+KIND_BITS-1:PW];
	assign rd_payload = slot_rd_s1[PW-1:0];
	assign range_bad  = req_s1.idx_bad || (CW'(idx_l) >= in_use_q);
	assign stale      = !rd_valid || (rd_gen != req_s1.gen);
	assign f_idx      = free_rd_s1[IW-1:0];
	assign f_gen      = free_rd_s1[FW-1:IW];
	assign next_gen   = (rd_gen == GEN_LAST) ? GEN_FIRST : rd_gen + 8'd1;
	assign free_wd    = {next_gen, idx_l};

	always_comb begin
		state_d     = state_q;
		req_pop     = 1'b0;
		done        = 1'b0;
		slot_we     = 1'b0;
		slot_wa     = idx_l;
		slot_wd     = slot_rd_s1;
		free_we     = 1'b0;
		in_use_inc  = 1'b0;
		fcount_inc  = 1'b0;
		fcount_dec  = 1'b0;
		status      = ST_OK;
		handle_out  = '0;
		payload_out = '0;
		kind_out    = '0;
		case (state_q)
			BK_IDLE: begin
				if (req_valid) begin
					req_pop = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				done = !out_valid_q || m_tready;
				case (req_s1.cmd)
					CMD_ALLOC: begin
						if (fcount_q != '0) begin
							fcount_dec = 1'b1;
							slot_wa    = f_idx;
							if (f_idx != '0 && CW'(f_idx) < CW'(SLOTS)) begin
								slot_we    = 1'b1;
								slot_wd    = {1'b1, f_gen, req_s1.kind, req_s1.payload[PW-1:0]};
								handle_out = {f_gen, INDEX_BITS'(f_idx)};
							end else begin
								status = ST_FULL;
							end
						end else if (in_use_q != CW'(SLOTS)) begin
							in_use_inc = 1'b1;
							slot_we    = 1'b1;
							slot_wa    = in_use_q[IW-1:0];
							slot_wd    = {1'b1, GEN_FIRST, req_s1.kind, req_s1.payload[PW-1:0]};
							handle_out = {GEN_FIRST, INDEX_BITS'(in_use_q[IW-1:0])};
						end else begin
							status = ST_FULL;
						end
					end
					CMD_LOOKUP: begin
						if (range_bad) begin
							status = ST_INVALID;
						end else if (stale) begin
							status = ST_STALE;
						end else if (req_s1.check && rd_kind != req_s1.kind) begin
							status = ST_KIND;
						end else begin
							payload_out = PORT_PAYLOAD'(rd_payload);
							kind_out    = rd_kind;
						end
					end
					CMD_RELEASE: begin
						if (!range_bad && !stale) begin
							slot_we = 1'b1;
							slot_wd = {1'b0, next_gen, rd_kind, rd_payload};
							if (fcount_q != CW'(SLOTS)) begin
								free_we    = 1'b1;
								fcount_inc = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
				if (!done) begin
					slot_we    = 1'b0;
					free_we    = 1'b0;
					in_use_inc = 1'b0;
					fcount_inc = 1'b0;
					fcount_dec = 1'b0;
				end else begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (req_pop) begin
			slot_rd_s1 <= slot_mem[req.idx[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[fcount_q[IW-1:0]] <= free_wd;
		end
		if (req_pop && fcount_q != '0) begin
			free_rd_s1 <= free_mem[IW'(fcount_q - CW'(1))];
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			req_s1 <= req;
		end
		if (done) begin
			out_data_q <= {3'b000, kind_out, payload_out, handle_out, status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			in_use_q    <= CW'(1);
			fcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_use_inc) begin
				in_use_q <= in_use_q + CW'(1);
			end
			if (fcount_inc) begin
				fcount_q <= fcount_q + CW'(1);
			end else if (fcount_dec) begin
				fcount_q <= fcount_q - CW'(1);
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_free_below_used: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q < in_use_q)
		else $error("free stack larger than used slots");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q != '0 && in_use_q <= CW'(SLOTS))
		else $error("slot use count out of range");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && req_s1.cmd == CMD_ALLOC && status == ST_FULL) |->
		(fcount_q == '0 && in_use_q == CW'(SLOTS)))
		else $error("table full reported with space left");

endmodule

// ----- hdl/generational_handle_table_unit.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table_unit
// Table of handle slots with generation counters: allocate, lookup, release.
// ----------------------------------------------------------------------------
// Input stream s_*: one command word per transfer, command in s_tuser.
// Output stream m_*: one result word for every command, in order.
// A handle is {generation[7:0], index[23:0]}; handle zero is null.
// Commands enter a two-entry queue, so input is taken while a result waits.
// In the execute unit each command is first read from the slot memory and
// free stack, then checked, updated and written back; the registered read
// of the slot memory ahead of its write-back sets this split.
// The execute unit takes a new command only after it is done with the last.
// Reset: table empty, slot zero reserved, free stack empty; no clearing
// pass, the slot use count bounds which entries are read.
// When m_tready is low the result is held, execution stops, and the queue
// fills and then drops s_tready.
// ----------------------------------------------------------------------------
module generational_handle_table_unit #(
	parameter int SLOTS        = 256,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// handle_in[31:0], kind_in[33:32], check_kind[34], payload_in[66:35], zero[71:67]
	input  logic [ght_pkg::S_TDATA_BITS-1:0] s_tdata,
	// command[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[2:0], handle_out[34:3], payload_out[66:35], kind_out[68:67], zero[71:69]
	output logic [ght_pkg::M_TDATA_BITS-1:0] m_tdata
);
	import ght_pkg::*;

	logic req_valid;
	logic req_pop;
	req_t req;

	ght_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.req_valid(req_valid),
		.req      (req),
		.req_pop  (req_pop)
	);

	ght_back #(
		.SLOTS       (SLOTS),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.req_pop  (req_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- dv/handle_table_checker.sv -----
// ----------------------------------------------------------------------------
// handle_table_checker
// Watches both streams of the handle table, keeps its own copy of the slot
// table and free list, and compares every result word with the answer it
// predicts for the command word that caused it.
// ----------------------------------------------------------------------------
module handle_table_checker
	import ght_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	// handle_in[31:0], kind_in[33:32], check_kind[34], payload_in[66:35], zero[71:67]
	input  logic [S_TDATA_BITS-1:0] s_tdata,
	// command[1:0]
	input  logic [1:0]              s_tuser,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	// status[2:0], handle_out[34:3], payload_out[66:35], kind_out[68:67], zero[71:69]
	input  logic [M_TDATA_BITS-1:0] m_tdata,
	output int                      fail_count,
	output int                      answers_due
);

	typedef struct packed {
		status_t                  status;
		logic [HANDLE_BITS-1:0]   handle;
		logic [PORT_PAYLOAD-1:0]  payload;
		logic [KIND_BITS-1:0]     kind;
	} answer_t;

	answer_t                 awaited[$];
	logic                    slot_live[SLOTS];
	logic [GEN_BITS-1:0]     slot_gen[SLOTS];
	logic [KIND_BITS-1:0]    slot_kind[SLOTS];
	logic [PORT_PAYLOAD-1:0] slot_data[SLOTS];
	logic [INDEX_BITS-1:0]   free_list[SLOTS];
	int unsigned             slots_used;
	int unsigned             free_depth;
	int                      reported;

	function automatic status_t vet_handle(input logic [HANDLE_BITS-1:0] h,
			output int unsigned idx);
		int unsigned i;
		i = 32'(h[INDEX_BITS-1:0]);
		idx = i;
		if (i == 0 || i >= slots_used || i >= SLOTS)
			return ST_INVALID;
		if (!slot_live[i] || slot_gen[i] != h[HANDLE_BITS-1:INDEX_BITS])
			return ST_STALE;
		return ST_OK;
	endfunction

	function automatic answer_t apply_table_command(input cmd_t cmd,
			input logic [HANDLE_BITS-1:0] handle, input logic [KIND_BITS-1:0] kind,
			input logic check, input logic [PORT_PAYLOAD-1:0] payload);
		answer_t     a;
		int unsigned idx;
		bit          have;
		a = '0;
		a.status = ST_OK;
		idx = 0;
		have = 1'b0;
		case (cmd)
			CMD_ALLOC: begin
				// freed slots first, most recent on top
				if (free_depth > 0) begin
					free_depth--;
					idx = 32'(free_list[free_depth]);
					have = idx != 0 && idx < SLOTS;
				end else if (slots_used < SLOTS) begin
					idx = slots_used;
					slots_used++;
					slot_gen[idx] = GEN_FIRST;
					have = 1'b1;
				end
				if (have) begin
					slot_data[idx] = payload;
					slot_kind[idx] = kind;
					slot_live[idx] = 1'b1;
					a.handle = {slot_gen[idx], INDEX_BITS'(idx)};
				end else begin
					a.status = ST_FULL;
				end
			end
			CMD_LOOKUP: begin
				a.status = vet_handle(handle, idx);
				if (a.status == ST_OK && check && slot_kind[idx] != kind)
					a.status = ST_KIND;
				if (a.status == ST_OK) begin
					a.payload = slot_data[idx];
					a.kind = slot_kind[idx];
				end
			end
			CMD_RELEASE: begin
				// bad handles are dropped silently
				if (vet_handle(handle, idx) == ST_OK) begin
					slot_live[idx] = 1'b0;
					slot_gen[idx] = (slot_gen[idx] == GEN_LAST) ? GEN_FIRST :
						slot_gen[idx] + 8'd1;
					if (free_depth < SLOTS) begin
						free_list[free_depth] = INDEX_BITS'(idx);
						free_depth++;
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic void note_mismatch(input string what, input answer_t want,
			input answer_t got);
		fail_count++;
		if (reported < 20)
			$display({"%0t handle table %s: expected status %0d handle %h payload %h",
				" kind %0d, got status %0d handle %h payload %h kind %0d"},
				$time, what, want.status, want.handle, want.payload, want.kind,
				got.status, got.handle, got.payload, got.kind);
		reported++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_live[i] = 1'b0;
				slot_gen[i] = '0;
				slot_kind[i] = '0;
				slot_data[i] = '0;
				free_list[i] = '0;
			end
			slots_used = 1;
			free_depth = 0;
			awaited.delete();
			answers_due <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[2:0], m_tdata[34:3], m_tdata[66:35], m_tdata[68:67]};
				if (awaited.size() == 0)
					note_mismatch("word with none due", '0, got);
				else if (got !== awaited[0])
					note_mismatch("mismatch", awaited.pop_front(), got);
				else
					void'(awaited.pop_front());
			end
			if (s_tvalid && s_tready)
				awaited.push_back(apply_table_command(cmd_t'(s_tuser), s_tdata[31:0],
					s_tdata[33:32], s_tdata[34], s_tdata[66:35]));
			answers_due <= awaited.size();
		end
	end

endmodule

// ----- dv/tb_generational_handle_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_generational_handle_table_unit
// Drives allocate, lookup, release and no-op words into the handle table with random
// gaps and output stalls: a directed opening, a fill past table full, a
// drain, a churn of one slot through generation wrap, then mixed traffic.
// The checker instance predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_generational_handle_table_unit;
	import ght_pkg::*;

	localparam int STUCK_LIMIT = 1000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata = '0;
	logic [1:0]              s_tuser = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0] m_tdata;

	int                      fail_count;
	int                      answers_due;
	int                      answers_seen = 0;
	int                      stuck_cycles = 0;
	bit                      steady_sender = 1'b0;
	logic [HANDLE_BITS-1:0]  live_handles[$];
	logic [HANDLE_BITS-1:0]  retired_handles[$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	generational_handle_table_unit #(
		.SLOTS(256),
		.PAYLOAD_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	handle_table_checker #(
		.SLOTS(256)
	) table_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fail_count(fail_count),
		.answers_due(answers_due)
	);

	// harvest issued handles on the falling edge ahead of the accepting edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			answers_seen++;
			if (m_tdata[2:0] == ST_OK && m_tdata[34:3] != '0)
				live_handles.push_back(m_tdata[34:3]);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_generational_handle_table_unit: FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// result side: random stalls, one long hold-off early on
	initial begin
		int hold;
		int r;
		bit steady;
		bit long_done;
		hold = 0;
		steady = 1'b0;
		long_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 127) == 0)
				steady = ~steady;
			r = $urandom_range(0, 99);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (!long_done && answers_seen >= 40) begin
				long_done = 1'b1;
				hold = 79;
				m_tready <= 1'b0;
			end else if (!steady && r >= 94) begin
				hold = $urandom_range(8, 25) - 1;
				m_tready <= 1'b0;
			end else if (!steady && r >= 60) begin
				hold = $urandom_range(1, 3) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic sender_gap();
		int n;
		int r;
		n = 0;
		r = $urandom_range(0, 99);
		if (!steady_sender) begin
			if (r >= 94)
				n = $urandom_range(8, 30);
			else if (r >= 60)
				n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_command(input cmd_t cmd, input logic [HANDLE_BITS-1:0] handle,
			input logic [KIND_BITS-1:0] kind, input logic check,
			input logic [PORT_PAYLOAD-1:0] payload);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {5'b0, payload, check, kind, handle};
		do @(posedge clk); while (!s_tready);
		sender_gap();
	endtask

	task automatic wait_all_answered();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (answers_due != 0);
	endtask

	task automatic retire(input logic [HANDLE_BITS-1:0] h);
		retired_handles.push_back(h);
		if (retired_handles.size() > 64)
			void'(retired_handles.pop_front());
	endtask

	function automatic logic [HANDLE_BITS-1:0] any_live();
		if (live_handles.size() == 0)
			return $urandom;
		return live_handles[$urandom_range(0, live_handles.size() - 1)];
	endfunction

	function automatic logic [HANDLE_BITS-1:0] any_retired();
		if (retired_handles.size() == 0)
			return $urandom;
		return retired_handles[$urandom_range(0, retired_handles.size() - 1)];
	endfunction

	task automatic send_allocate();
		send_command(CMD_ALLOC, $urandom, 2'($urandom_range(0, 3)),
			1'($urandom_range(0, 1)), $urandom);
	endtask

	task automatic send_lookup();
		logic [HANDLE_BITS-1:0] h;
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			h = any_live();
		else if (r < 75)
			h = any_retired();
		else if (r < 85)
			h = any_live() ^ (32'h1 << (INDEX_BITS + $urandom_range(0, GEN_BITS - 1)));
		else if (r < 93)
			h = {8'($urandom), 24'h0};
		else
			h = $urandom;
		send_command(CMD_LOOKUP, h, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			$urandom);
	endtask

	task automatic send_release();
		logic [HANDLE_BITS-1:0] h;
		int r;
		int i;
		r = $urandom_range(0, 99);
		if (r < 80 && live_handles.size() > 0) begin
			i = $urandom_range(0, live_handles.size() - 1);
			h = live_handles[i];
			live_handles.delete(i);
			retire(h);
		end else if (r < 90) begin
			h = any_retired();
		end else begin
			h = $urandom;
		end
		send_command(CMD_RELEASE, h, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			$urandom);
	endtask

	task automatic run_traffic_mix(input int n, input int w_alloc, input int w_lookup,
			input int w_release);
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0)
				steady_sender = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < w_alloc)
				send_allocate();
			else if (r < w_alloc + w_lookup)
				send_lookup();
			else if (r < w_alloc + w_lookup + w_release)
				send_release();
			else
				send_command(CMD_NOP, $urandom, 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), $urandom);
		end
		steady_sender = 1'b0;
	endtask

	// alloc/release on the top free slot, walking its generation through the wrap
	task automatic churn_one_slot(input int n);
		logic [HANDLE_BITS-1:0] h;
		for (int i = 0; i < n; i++) begin
			send_allocate();
			wait_all_answered();
			if (live_handles.size() > 0) begin
				h = live_handles.pop_back();
				if ($urandom_range(0, 7) == 0)
					send_command(CMD_LOOKUP, h, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), $urandom);
				send_command(CMD_RELEASE, h, 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), $urandom);
				retire(h);
				if ($urandom_range(0, 7) == 0)
					send_command(CMD_LOOKUP, h, 2'($urandom_range(0, 3)), 1'b0, $urandom);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(CMD_LOOKUP, '0, 2'd0, 1'b0, '0);
		send_command(CMD_RELEASE, '0, 2'd0, 1'b0, '0);
		send_command(CMD_NOP, '1, 2'd3, 1'b1, '1);
		send_command(CMD_ALLOC, '1, 2'd0, 1'b1, '0);
		send_command(CMD_ALLOC, '0, 2'd3, 1'b0, '1);
		send_command(CMD_LOOKUP, {GEN_FIRST, 24'd1}, 2'd0, 1'b1, '0);
		send_command(CMD_LOOKUP, {GEN_FIRST, 24'd2}, 2'd1, 1'b1, '0);
		send_command(CMD_LOOKUP, {GEN_FIRST, 24'd2}, 2'd1, 1'b0, '1);
		send_command(CMD_LOOKUP, {8'd2, 24'd1}, 2'd0, 1'b0, '0);
		send_command(CMD_LOOKUP, {GEN_FIRST, 24'd3}, 2'd0, 1'b0, '0);
		send_command(CMD_LOOKUP, '1, 2'd3, 1'b1, '1);
		send_command(CMD_LOOKUP, {GEN_LAST, 24'd0}, 2'd0, 1'b0, '0);
		send_command(CMD_RELEASE, {GEN_FIRST, 24'd1}, 2'd0, 1'b0, '0);
		send_command(CMD_LOOKUP, {GEN_FIRST, 24'd1}, 2'd0, 1'b0, '0);
		send_command(CMD_RELEASE, {GEN_FIRST, 24'd1}, 2'd0, 1'b0, '0);
		send_command(CMD_ALLOC, '0, 2'd2, 1'b0, 32'ha5a5a5a5);
		send_command(CMD_LOOKUP, {8'd2, 24'd1}, 2'd2, 1'b1, '0);
		send_command(CMD_RELEASE, {GEN_FIRST, 24'd2}, 2'd0, 1'b0, '0);
		send_command(CMD_ALLOC, '0, 2'd1, 1'b0, 32'h5a5a5a5a);
		send_command(CMD_LOOKUP, {8'd2, 24'd2}, 2'd1, 1'b1, '0);
		send_command(CMD_RELEASE, {8'd2, 24'd1}, 2'd0, 1'b0, '0);
		send_command(CMD_RELEASE, {8'd2, 24'd2}, 2'd0, 1'b0, '0);
		wait_all_answered();
		while (live_handles.size() > 0)
			retire(live_handles.pop_front());

		run_traffic_mix(400, 78, 12, 8);
		wait_all_answered();
		run_traffic_mix(250, 12, 28, 58);
		wait_all_answered();
		churn_one_slot(262);
		run_traffic_mix(120, 30, 35, 25);
		wait_all_answered();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && answers_due == 0)
			$display("tb_generational_handle_table_unit: PASS");
		else
			$display("tb_generational_handle_table_unit: FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/ght_pkg.sv
hdl/ght_front.sv
hdl/ght_back.sv
hdl/generational_handle_table_unit.sv
dv/handle_table_checker.sv
dv/tb_generational_handle_table_unit.sv
